// ===== src/lfc_pkg.sv =====
// Shared types and constants for the font list cache.
// Used by the top level and the testbench; depends on nothing.
package lfc_pkg;

    localparam int DEFAULT_ENTRIES = 30;

    localparam int WIN_W      = 16;
    localparam int KEY_W      = 28;
    localparam int BASE_W     = 14;
    localparam int REMOVED_W  = 5;
    localparam int BASE_SUM_W = 20;

    localparam int BASE_START = 1000;
    localparam int BASE_STEP  = 260;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic MODE_LOOKUP  = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } lfc_state_t;

endpackage

// ===== src/lfc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lfc_free_pick.sv =====
// Picks the smallest resource index k >= 1 whose bit (k-1) is clear in the used map.
// Depends on nothing but its parameters.
module lfc_free_pick #(
    parameter int ENTRIES = 30
) (
    input  logic [ENTRIES-1:0]           used,
    output logic [$clog2(ENTRIES+1)-1:0] free_k
);

    localparam int BW = $clog2(ENTRIES + 1);

    always_comb begin
        free_k = BW'(ENTRIES);
        for (int k = ENTRIES; k >= 1; k--) begin
            if (!used[k-1]) begin
                free_k = BW'(k);
            end
        end
    end

endmodule

// ===== src/lru_font_list_cache.sv =====
// Top level of the move-to-front font list cache: sequencer, list memory, result register.
// Depends on lfc_pkg, lfc_ram and lfc_free_pick.
//
//  channel | ports          | contents
//  --------+----------------+----------------------------------------------------------
//  input   | s_tvalid/ready | s_tuser = mode; s_tdata = window, italic, bold, size, family
//  result  | m_tvalid/ready | m_tdata = list_base, hit, evicted, evicted_base, removed_count
//
// The list lives in one RAM ordered by recency; each item scans it one entry per cycle.
// A new item is taken only in the idle state, after the last one has placed its result in the
// output register; a hit stops the scan at its position, a miss and a release scan every entry,
// an item on an empty list skips the scan, and the single read and write port paces the scan.
// Reset clears only the state, the entry count and the result valid flag; no clearing pass over the memory is needed.
// A finished result waits in the output register while the next item is accepted.
module lru_font_list_cache #(
    parameter int ENTRIES = lfc_pkg::DEFAULT_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] window_id, [16] italic, [17] bold, [25:18] font_size, [27:26] font_family
    input  logic [lfc_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [13:0] list_base, [14] hit, [15] evicted, [29:16] evicted_base, [34:30] removed_count
    output logic [lfc_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int AW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int BW    = $clog2(ENTRIES + 1);
    localparam int KEY_W = lfc_pkg::KEY_W;
    localparam int WIN_W = lfc_pkg::WIN_W;
    localparam int DW    = KEY_W + BW;
    localparam int SW    = lfc_pkg::BASE_SUM_W;

    lfc_pkg::lfc_state_t state_reg, state_next;

    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    kept_reg, kept_next;
    logic [CW-1:0]    removed_reg, removed_next;
    logic [DW-1:0]    held_reg, held_next;
    logic [ENTRIES-1:0] used_reg, used_next;
    logic             mode_reg, mode_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [BW-1:0]    base_reg, base_next;
    logic             hit_reg, hit_next;
    logic             evict_reg, evict_next;
    logic             m_valid_reg, m_valid_next;
    logic [lfc_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [KEY_W-1:0] rd_key;
    logic [BW-1:0]    rd_base;
    logic             last_entry;
    logic [BW-1:0]    free_k;
    logic [SW-1:0]    base_sum;
    logic [lfc_pkg::BASE_W-1:0] list_base;
    logic [lfc_pkg::BASE_W-1:0] evict_base;

    lfc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_list_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lfc_free_pick #(
        .ENTRIES (ENTRIES)
    ) u_free_pick (
        .used   (used_reg),
        .free_k (free_k)
    );

    assign rd_key     = ram_rdata[DW-1:BW];
    assign rd_base    = ram_rdata[BW-1:0];
    assign last_entry = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign base_sum   = SW'(lfc_pkg::BASE_START) + SW'(lfc_pkg::BASE_STEP) * SW'(base_reg);
    assign list_base  = (mode_reg == lfc_pkg::MODE_RELEASE) ? '0
                                                            : base_sum[lfc_pkg::BASE_W-1:0];
    assign evict_base = evict_reg ? list_base : '0;

    assign s_tready = (state_reg == lfc_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lfc_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg     <= idx_next;
        kept_reg    <= kept_next;
        removed_reg <= removed_next;
        held_reg    <= held_next;
        used_reg    <= used_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        base_reg    <= base_next;
        hit_reg     <= hit_next;
        evict_reg   <= evict_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        kept_next    = kept_reg;
        removed_next = removed_reg;
        held_next    = held_reg;
        used_next    = used_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        base_next    = base_reg;
        hit_next     = hit_reg;
        evict_next   = evict_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = held_reg;
        ram_raddr    = '0;

        case (state_reg)
            lfc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next    = s_tuser;
                    key_next     = {s_tdata[15:0], s_tdata[16], s_tdata[17],
                                    s_tdata[25:18], s_tdata[27:26]};
                    idx_next     = '0;
                    kept_next    = '0;
                    removed_next = '0;
                    used_next    = '0;
                    hit_next     = 1'b0;
                    evict_next   = 1'b0;
                    base_next    = BW'(1);
                    // Entry 0 is being read this cycle for the scan.
                    state_next   = (count_reg == '0) ? lfc_pkg::ST_DONE : lfc_pkg::ST_SCAN;
                end
            end

            lfc_pkg::ST_SCAN: begin
                ram_raddr = AW'(CW'(idx_reg) + CW'(1));
                if (mode_reg == lfc_pkg::MODE_RELEASE) begin
                    if (rd_key[KEY_W-1 -: WIN_W] == key_reg[KEY_W-1 -: WIN_W]) begin
                        removed_next = removed_reg + CW'(1);
                    end else begin
                        // Compact the survivors toward the front, keeping their order.
                        ram_we    = 1'b1;
                        ram_waddr = AW'(kept_reg);
                        ram_wdata = ram_rdata;
                        kept_next = kept_reg + CW'(1);
                    end
                    if (last_entry) begin
                        count_next = kept_next;
                        state_next = lfc_pkg::ST_DONE;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end else begin
                    // Each scanned slot takes the entry in front of it, which opens slot 0.
                    if (idx_reg != '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                        ram_wdata = held_reg;
                    end
                    if (rd_key == key_reg) begin
                        hit_next   = 1'b1;
                        base_next  = rd_base;
                        state_next = lfc_pkg::ST_DONE;
                    end else begin
                        held_next = ram_rdata;
                        used_next[AW'(rd_base - BW'(1))] = 1'b1;
                        if (last_entry) begin
                            if (count_reg == CW'(ENTRIES)) begin
                                // The last entry drops out and its base is reused.
                                evict_next = 1'b1;
                                base_next  = rd_base;
                                state_next = lfc_pkg::ST_DONE;
                            end else begin
                                state_next = lfc_pkg::ST_TAIL;
                            end
                        end else begin
                            idx_next = idx_reg + AW'(1);
                        end
                    end
                end
            end

            lfc_pkg::ST_TAIL: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(count_reg);
                ram_wdata  = held_reg;
                base_next  = free_k;
                state_next = lfc_pkg::ST_DONE;
            end

            lfc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(lfc_pkg::M_DATA_W - 35){1'b0}},
                                    lfc_pkg::REMOVED_W'(removed_reg),
                                    evict_base, evict_reg, hit_reg, list_base};
                    if (mode_reg == lfc_pkg::MODE_LOOKUP) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = {key_reg, base_reg};
                        if (!hit_reg && !evict_reg) begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    state_next = lfc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lfc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/tb_lru_font_list_cache.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the move-to-front font list cache.
// Depends on lfc_pkg and lru_font_list_cache; keeps its own model of the list order and bases.
module tb_lru_font_list_cache;
    import lfc_pkg::*;

    localparam int ENTRIES        = DEFAULT_ENTRIES;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 2 * ENTRIES + 10;
    localparam int DIR_ROWS       = 18;

    typedef struct packed {
        logic              mode;
        logic [WIN_W-1:0]  win;
        logic              ital;
        logic              bold;
        logic [7:0]        size;
        logic [1:0]        fam;
    } font_req_t;

    // Same bit order as m_tdata, lowest field last.
    typedef struct packed {
        logic [REMOVED_W-1:0] removed;
        logic [BASE_W-1:0]    ev_base;
        logic                 ev;
        logic                 hit;
        logic [BASE_W-1:0]    base;
    } font_res_t;

    typedef struct packed {
        font_req_t req;
        logic      typed;
        font_res_t res;
    } dir_row_t;

    localparam logic [WIN_W-1:0] WIN_POOL [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hABCD};
    localparam logic [7:0] SIZE_POOL [2] = '{8'd12, 8'd255};

    // Rows with typed = 0 take their expected result from the predictor.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{MODE_RELEASE, 16'h0000, 1'b0, 1'b0, 8'd0,   2'd0}, 1'b1,
          '{5'd0, 14'd0, 1'b0, 1'b0, 14'd0}},
        '{'{MODE_LOOKUP,  16'h0000, 1'b0, 1'b0, 8'd0,   2'd0}, 1'b1,
          '{5'd0, 14'd0, 1'b0, 1'b0, 14'd1260}},
        '{'{MODE_LOOKUP,  16'h0000, 1'b0, 1'b0, 8'd0,   2'd0}, 1'b1,
          '{5'd0, 14'd0, 1'b0, 1'b1, 14'd1260}},
        '{'{MODE_LOOKUP,  16'hFFFF, 1'b1, 1'b1, 8'd255, 2'd3}, 1'b1,
          '{5'd0, 14'd0, 1'b0, 1'b0, 14'd1520}},
        '{'{MODE_LOOKUP,  16'h0000, 1'b0, 1'b0, 8'd0,   2'd0}, 1'b1,
          '{5'd0, 14'd0, 1'b0, 1'b1, 14'd1260}},
        '{'{MODE_LOOKUP,  16'h0000, 1'b1, 1'b0, 8'd0,   2'd0}, 1'b0, '0},
        '{'{MODE_LOOKUP,  16'h0000, 1'b0, 1'b1, 8'd0,   2'd0}, 1'b0, '0},
        '{'{MODE_LOOKUP,  16'hFFFF, 1'b0, 1'b0, 8'd0,   2'd0}, 1'b0, '0},
        '{'{MODE_RELEASE, 16'hFFFF, 1'b1, 1'b1, 8'd255, 2'd3}, 1'b0, '0},
        '{'{MODE_RELEASE, 16'hFFFF, 1'b0, 1'b0, 8'd0,   2'd0}, 1'b1,
          '{5'd0, 14'd0, 1'b0, 1'b0, 14'd0}},
        '{'{MODE_LOOKUP,  16'hA5A5, 1'b0, 1'b1, 8'h5A,  2'd2}, 1'b0, '0},
        '{'{MODE_LOOKUP,  16'h5A5A, 1'b1, 1'b0, 8'hA5,  2'd1}, 1'b0, '0},
        '{'{MODE_LOOKUP,  16'h0000, 1'b1, 1'b0, 8'd0,   2'd0}, 1'b0, '0},
        '{'{MODE_LOOKUP,  16'h0001, 1'b0, 1'b0, 8'd128, 2'd1}, 1'b0, '0},
        '{'{MODE_LOOKUP,  16'h8000, 1'b0, 1'b0, 8'd127, 2'd2}, 1'b0, '0},
        '{'{MODE_RELEASE, 16'h0000, 1'b1, 1'b0, 8'd7,   2'd1}, 1'b0, '0},
        '{'{MODE_LOOKUP,  16'h0001, 1'b0, 1'b0, 8'd128, 2'd1}, 1'b0, '0},
        '{'{MODE_RELEASE, 16'h8000, 1'b0, 1'b0, 8'd0,   2'd0}, 1'b0, '0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    logic [KEY_W-1:0]      cache_key [ENTRIES];
    logic [4:0]            cache_kidx [ENTRIES];
    int                    cache_fill;

    font_res_t             font_answers_q [$];
    int                    mismatch_cnt;
    int                    tx_idle;
    int                    rx_idle;
    bit                    hold_req;

    lru_font_list_cache #(.ENTRIES(ENTRIES)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [BASE_W-1:0] list_base_of(input logic [4:0] k);
        int b;
        b = BASE_START + BASE_STEP * k;
        return b[BASE_W-1:0];
    endfunction

    // Updates the cache image for one accepted request and returns its result.
    function automatic font_res_t predict_font(input font_req_t rq);
        font_res_t        res;
        logic [KEY_W-1:0] key;
        logic [4:0]       k;
        int               kept;
        int               removed;
        int               pos;
        int               i;
        int               c;
        bit               used;
        res = '0;
        key = {rq.win, rq.ital, rq.bold, rq.size, rq.fam};
        if (rq.mode == MODE_RELEASE) begin
            kept    = 0;
            removed = 0;
            for (i = 0; i < cache_fill; i++) begin
                if (cache_key[i][KEY_W-1 -: WIN_W] == rq.win) begin
                    removed++;
                end else begin
                    cache_key[kept]  = cache_key[i];
                    cache_kidx[kept] = cache_kidx[i];
                    kept++;
                end
            end
            cache_fill  = kept;
            res.removed = removed[REMOVED_W-1:0];
            return res;
        end
        pos = -1;
        for (i = 0; i < cache_fill; i++) begin
            if (pos < 0 && cache_key[i] == key) pos = i;
        end
        if (pos >= 0) begin
            k       = cache_kidx[pos];
            res.hit = 1'b1;
        end else if (cache_fill >= ENTRIES) begin
            // The least recently used entry gives up its base to the new key.
            k           = cache_kidx[ENTRIES-1];
            pos         = ENTRIES - 1;
            res.ev      = 1'b1;
            res.ev_base = list_base_of(k);
        end else begin
            k = 5'(ENTRIES);
            for (c = ENTRIES; c >= 1; c--) begin
                used = 1'b0;
                for (i = 0; i < cache_fill; i++) begin
                    if (cache_kidx[i] == 5'(c)) used = 1'b1;
                end
                if (!used) k = 5'(c);
            end
            pos = cache_fill;
            cache_fill++;
        end
        for (i = pos; i > 0; i--) begin
            cache_key[i]  = cache_key[i-1];
            cache_kidx[i] = cache_kidx[i-1];
        end
        cache_key[0]  = key;
        cache_kidx[0] = k;
        res.base      = list_base_of(k);
        return res;
    endfunction

    // Mostly keys from a small pool so that hits, evictions and releases are frequent.
    function automatic font_req_t rand_font_req();
        font_req_t rq;
        int        pick;
        pick    = $urandom_range(99);
        rq.mode = MODE_LOOKUP;
        rq.win  = WIN_POOL[$urandom_range(3)];
        rq.ital = 1'($urandom_range(1));
        rq.bold = 1'($urandom_range(1));
        rq.size = SIZE_POOL[$urandom_range(1)];
        rq.fam  = 2'($urandom_range(1));
        if (pick < 8) begin
            rq.mode = MODE_RELEASE;
            rq.size = 8'($urandom_range(255));
            rq.fam  = 2'($urandom_range(3));
        end else if (pick < 10) begin
            rq.mode = MODE_RELEASE;
            rq.win  = 16'($urandom_range(16'hFFFF));
        end else if (pick < 25) begin
            rq.win  = 16'($urandom_range(16'hFFFF));
            rq.size = 8'($urandom_range(255));
            rq.fam  = 2'($urandom_range(3));
        end
        return rq;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer took place.
    task automatic send_font(input font_req_t rq, input bit typed, input font_res_t typed_res);
        font_res_t pred;
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.mode;
        s_tdata  <= S_DATA_W'({rq.fam, rq.size, rq.bold, rq.ital, rq.win});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_font(rq);
        font_answers_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (font_answers_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic void check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        font_res_t got;
        font_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(font_res_t)-1:0];
            if (font_answers_q.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, m_tdata);
                mismatch_cnt++;
            end else begin
                want = font_answers_q.pop_front();
                check_field("list_base", want.base, got.base);
                check_field("hit", want.hit, got.hit);
                check_field("evicted", want.ev, got.ev);
                check_field("evicted_base", want.ev_base, got.ev_base);
                check_field("removed_count", want.removed, got.removed);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        bit hold_seen;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        font_req_t rq;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = 1'b0;
        s_tdata      = '0;
        hold_req     = 1'b0;
        mismatch_cnt = 0;
        cache_fill   = 0;
        tx_idle      = 27;
        rx_idle      = 27;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_TABLE[i]) begin
            send_font(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].res);
        end

        repeat (130) send_font(rand_font_req(), 1'b0, '0);

        // Stall the result side long enough for the block to back up its input.
        hold_req = 1'b1;
        repeat (24) send_font(rand_font_req(), 1'b0, '0);
        wait_drained();

        tx_idle = 0;
        rx_idle = 0;
        repeat (100) send_font(rand_font_req(), 1'b0, '0);
        tx_idle = 27;
        rx_idle = 27;

        // Distinct windows overflow the list and force evictions.
        for (int i = 0; i < ENTRIES + 5; i++) begin
            rq.mode = MODE_LOOKUP;
            rq.win  = 16'h0F00 + 16'(i);
            rq.ital = 1'($urandom_range(1));
            rq.bold = 1'($urandom_range(1));
            rq.size = 8'($urandom_range(255));
            rq.fam  = 2'($urandom_range(3));
            send_font(rq, 1'b0, '0);
        end

        repeat (130) send_font(rand_font_req(), 1'b0, '0);
        wait_drained();

        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
